// File: rtl/ced_pkg.sv
// ----------------------------------------------------------------------------
// ced_pkg
// Shared types and character constants for the escape sequence decoder.
// ----------------------------------------------------------------------------
package ced_pkg;

  // Decoder modes
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_OCT    = 3'd2,
    MODE_HEX0   = 3'd3,
    MODE_HEX1   = 3'd4
  } ced_mode_t;

  // Characters that steer decoding
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_X      = 8'h78;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_SEVEN  = 8'h37;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_LC_A   = 8'h61;
  localparam logic [7:0] CHAR_LC_F   = 8'h66;
  localparam logic [7:0] CHAR_UC_A   = 8'h41;
  localparam logic [7:0] CHAR_UC_F   = 8'h46;

  // Letters of the single-character escapes
  localparam logic [7:0] ESC_BELL_CH = 8'h61; // a
  localparam logic [7:0] ESC_BS_CH   = 8'h62; // b
  localparam logic [7:0] ESC_TAB_CH  = 8'h74; // t
  localparam logic [7:0] ESC_LF_CH   = 8'h6E; // n
  localparam logic [7:0] ESC_VT_CH   = 8'h76; // v
  localparam logic [7:0] ESC_FF_CH   = 8'h66; // f
  localparam logic [7:0] ESC_CR_CH   = 8'h72; // r

  // Control codes they map to
  localparam logic [7:0] CODE_BELL = 8'd7;
  localparam logic [7:0] CODE_BS   = 8'd8;
  localparam logic [7:0] CODE_TAB  = 8'd9;
  localparam logic [7:0] CODE_LF   = 8'd10;
  localparam logic [7:0] CODE_VT   = 8'd11;
  localparam logic [7:0] CODE_FF   = 8'd12;
  localparam logic [7:0] CODE_CR   = 8'd13;

  // Result queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } ced_result_t;

  // Results produced by one input byte: up to two
  typedef struct packed {
    logic [1:0]  num;
    ced_result_t res0;
    ced_result_t res1;
  } ced_dec_out_t;

endpackage

// File: rtl/ced_chan_if.sv
// ----------------------------------------------------------------------------
// ced_chan_if
// Valid/ready channels for input characters and decoded bytes.
// ----------------------------------------------------------------------------
interface ced_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface ced_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_end;

  modport source (output valid, output out_byte, output run_last, output string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_end,
                  output ready);
endinterface

// File: rtl/ced_decoder.sv
// ----------------------------------------------------------------------------
// ced_decoder
// Escape state machine: turns one accepted character into zero to two results.
// ----------------------------------------------------------------------------
module ced_decoder (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  output ced_pkg::ced_dec_out_t dec_out
);

  ced_pkg::ced_mode_t mode_r, mode_nxt;
  logic [8:0]         value_r, value_nxt;
  logic [1:0]         count_r, count_nxt;

  logic       is_oct, is_hex, do_plain;
  logic [3:0] hex_val;
  logic [7:0] ctrl_val;
  logic [8:0] oct_acc;
  logic [1:0] count_inc;
  logic [1:0] num;
  logic [7:0] e0, e1;

  always_comb begin
    is_oct = (in_byte >= ced_pkg::CHAR_ZERO) && (in_byte <= ced_pkg::CHAR_SEVEN);
    is_hex = 1'b1;
    hex_val = 4'd0;
    if ((in_byte >= ced_pkg::CHAR_ZERO) && (in_byte <= ced_pkg::CHAR_NINE)) begin
      hex_val = 4'(in_byte - ced_pkg::CHAR_ZERO);
    end else if ((in_byte >= ced_pkg::CHAR_LC_A) && (in_byte <= ced_pkg::CHAR_LC_F)) begin
      hex_val = 4'(in_byte - ced_pkg::CHAR_LC_A + 8'd10);
    end else if ((in_byte >= ced_pkg::CHAR_UC_A) && (in_byte <= ced_pkg::CHAR_UC_F)) begin
      hex_val = 4'(in_byte - ced_pkg::CHAR_UC_A + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    case (in_byte)
      ced_pkg::ESC_BELL_CH: ctrl_val = ced_pkg::CODE_BELL;
      ced_pkg::ESC_BS_CH:   ctrl_val = ced_pkg::CODE_BS;
      ced_pkg::ESC_TAB_CH:  ctrl_val = ced_pkg::CODE_TAB;
      ced_pkg::ESC_LF_CH:   ctrl_val = ced_pkg::CODE_LF;
      ced_pkg::ESC_VT_CH:   ctrl_val = ced_pkg::CODE_VT;
      ced_pkg::ESC_FF_CH:   ctrl_val = ced_pkg::CODE_FF;
      ced_pkg::ESC_CR_CH:   ctrl_val = ced_pkg::CODE_CR;
      default:              ctrl_val = in_byte;
    endcase
  end

  always_comb begin
    mode_nxt  = mode_r;
    value_nxt = value_r;
    count_nxt = count_r;
    num       = 2'd0;
    e0        = 8'd0;
    e1        = 8'd0;
    do_plain  = 1'b0;
    oct_acc   = {value_r[5:0], in_byte[2:0]};
    count_inc = count_r + 2'd1;

    case (mode_r)
      ced_pkg::MODE_ESC: begin
        if (is_oct) begin
          mode_nxt  = ced_pkg::MODE_OCT;
          value_nxt = {6'd0, in_byte[2:0]};
          count_nxt = 2'd1;
        end else if (in_byte == ced_pkg::CHAR_X) begin
          mode_nxt  = ced_pkg::MODE_HEX0;
          value_nxt = 9'd0;
        end else begin
          mode_nxt = ced_pkg::MODE_NORMAL;
          e0       = ctrl_val;
          num      = 2'd1;
        end
      end
      ced_pkg::MODE_OCT: begin
        if (is_oct) begin
          value_nxt = oct_acc;
          count_nxt = count_inc;
          if (count_inc == 2'd3) begin
            mode_nxt = ced_pkg::MODE_NORMAL;
            e0       = oct_acc[7:0];
            num      = 2'd1;
          end
        end else begin
          e0       = value_r[7:0];
          num      = 2'd1;
          do_plain = 1'b1;
        end
      end
      ced_pkg::MODE_HEX0: begin
        if (is_hex) begin
          mode_nxt  = ced_pkg::MODE_HEX1;
          value_nxt = {5'd0, hex_val};
        end else begin
          e0       = ced_pkg::CHAR_X;
          num      = 2'd1;
          do_plain = 1'b1;
        end
      end
      ced_pkg::MODE_HEX1: begin
        if (is_hex) begin
          mode_nxt = ced_pkg::MODE_NORMAL;
          e0       = {value_r[3:0], hex_val};
          num      = 2'd1;
        end else begin
          e0       = value_r[7:0];
          num      = 2'd1;
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    // Ordinary character handling; a backslash opens a new escape
    if (do_plain) begin
      if (in_byte == ced_pkg::CHAR_BSLASH) begin
        mode_nxt = ced_pkg::MODE_ESC;
      end else begin
        mode_nxt = ced_pkg::MODE_NORMAL;
        if (num == 2'd0) begin
          e0 = in_byte;
        end else begin
          e1 = in_byte;
        end
        num = num + 2'd1;
      end
    end

    // Flush a pending value at end of string
    if (in_last) begin
      if ((mode_nxt == ced_pkg::MODE_OCT) || (mode_nxt == ced_pkg::MODE_HEX1) ||
          (mode_nxt == ced_pkg::MODE_HEX0)) begin
        if (num == 2'd0) begin
          e0 = (mode_nxt == ced_pkg::MODE_HEX0) ? ced_pkg::CHAR_X : value_nxt[7:0];
        end else begin
          e1 = (mode_nxt == ced_pkg::MODE_HEX0) ? ced_pkg::CHAR_X : value_nxt[7:0];
        end
        num = num + 2'd1;
      end
      mode_nxt = ced_pkg::MODE_NORMAL;
    end

    if (mode_nxt == ced_pkg::MODE_NORMAL) begin
      value_nxt = 9'd0;
      count_nxt = 2'd0;
    end
  end

  always_comb begin
    dec_out.num             = fire ? num : 2'd0;
    dec_out.res0.out_byte   = e0;
    dec_out.res0.run_last   = (num == 2'd1);
    dec_out.res0.string_end = in_last;
    dec_out.res1.out_byte   = e1;
    dec_out.res1.run_last   = 1'b1;
    dec_out.res1.string_end = in_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ced_pkg::MODE_NORMAL;
      value_r <= 9'd0;
      count_r <= 2'd0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      value_r <= value_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// File: rtl/ced_out_queue.sv
// ----------------------------------------------------------------------------
// ced_out_queue
// Small result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module ced_out_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ced_pkg::ced_dec_out_t push,
  output logic                  has_room,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ced_pkg::ced_result_t  out_res
);

  ced_pkg::ced_result_t q_r [ced_pkg::QDEPTH];

  logic [ced_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ced_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ced_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic [ced_pkg::QPTR_W-1:0] wr_ptr_p1;
  logic                       pop;

  // Room for a worst-case pair of results, judged on the registered count
  assign has_room  = (count_r <= ced_pkg::QCNT_W'(ced_pkg::QDEPTH - 2));
  assign out_valid = (count_r != '0);
  assign out_res   = q_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + ced_pkg::QPTR_W'(push.num);
    rd_ptr_nxt = rd_ptr_r + ced_pkg::QPTR_W'(pop);
    count_nxt  = count_r + ced_pkg::QCNT_W'(push.num) - ced_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      q_r[wr_ptr_r] <= push.res0;
    end
    if (push.num == 2'd2) begin
      q_r[wr_ptr_p1] <= push.res1;
    end
  end

endmodule

// File: rtl/c_escape_sequence_decoder_unit.sv
// Results pass through the registered result queue before appearing on out_chan.
// Throughput: one character per cycle while each yields at most one byte; a
//   two-byte character's bytes leave one per output transfer, and input
//   stalls when the four-entry result queue cannot take another pair.
// Reset: synchronous active-low rst_n returns the decoder to normal mode and
//   empties the result queue.
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder_unit
// Decodes C escape sequences in a character stream, one character per transfer.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder_unit (
  input  logic          clk,
  input  logic          rst_n,
  ced_in_if.sink        in_chan,
  ced_out_if.source     out_chan
);

  ced_pkg::ced_dec_out_t dec_out;
  ced_pkg::ced_result_t  res;
  logic                  has_room;
  logic                  in_fire;

  assign in_chan.ready = has_room;
  assign in_fire       = in_chan.valid && has_room;

  ced_decoder u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .in_byte (in_chan.in_byte),
    .in_last (in_chan.in_last),
    .dec_out (dec_out)
  );

  ced_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (dec_out),
    .has_room  (has_room),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (res)
  );

  assign out_chan.out_byte   = res.out_byte;
  assign out_chan.run_last   = res.run_last;
  assign out_chan.string_end = res.string_end;

endmodule

// File: bench/c_escape_sequence_decoder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder_unit_tb
// Feeds strings with C escapes through the decoder: a short directed list
// followed by random, mostly well-formed strings. A scoreboard tracks the
// decoder state, predicts every decoded byte and checks the result channel.
// Random gaps fall on both channels, plus one long output hold-off and
// a full drain mid-run.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder_unit_tb;

  localparam int RANDOM_ITEMS = 650;
  localparam int HOLD_AT      = 150;
  localparam int PAUSE_AT     = 320;
  localparam int SMOOTH_FROM  = 450;
  localparam int SMOOTH_TO    = 560;
  localparam int HOLD_CYCLES  = 80;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  // Tracks decoder state and the queue of bytes still to come out
  class decoded_byte_tracker;
    ced_pkg::ced_mode_t   mode;
    logic [8:0]           acc_value;
    logic [1:0]           oct_digits;
    ced_pkg::ced_result_t expected_bytes[$];
    ced_pkg::ced_result_t step_bytes[$];
    int                   mismatches;

    function new();
      mode       = ced_pkg::MODE_NORMAL;
      acc_value  = '0;
      oct_digits = '0;
      mismatches = 0;
    endfunction

    function bit is_oct(logic [7:0] b);
      return b >= ced_pkg::CHAR_ZERO && b <= ced_pkg::CHAR_SEVEN;
    endfunction

    function bit is_hex(logic [7:0] b);
      return (b >= ced_pkg::CHAR_ZERO && b <= ced_pkg::CHAR_NINE) ||
             (b >= ced_pkg::CHAR_LC_A && b <= ced_pkg::CHAR_LC_F) ||
             (b >= ced_pkg::CHAR_UC_A && b <= ced_pkg::CHAR_UC_F);
    endfunction

    function logic [3:0] hex_digit(logic [7:0] b);
      logic [7:0] v;
      if (b >= ced_pkg::CHAR_LC_A) v = b - ced_pkg::CHAR_LC_A + 8'd10;
      else if (b >= ced_pkg::CHAR_UC_A) v = b - ced_pkg::CHAR_UC_A + 8'd10;
      else v = b - ced_pkg::CHAR_ZERO;
      return v[3:0];
    endfunction

    function void put(logic [7:0] v, logic last);
      ced_pkg::ced_result_t r;
      r.out_byte   = v;
      r.run_last   = 1'b0;
      r.string_end = last;
      step_bytes.push_back(r);
    endfunction

    // Normal-mode handling: a backslash opens an escape, anything else passes
    function void take_plain(logic [7:0] b, logic last);
      if (b == ced_pkg::CHAR_BSLASH) begin
        mode = ced_pkg::MODE_ESC;
      end else begin
        mode = ced_pkg::MODE_NORMAL;
        put(b, last);
      end
    endfunction

    function void note_char(logic [7:0] b, logic last);
      logic [7:0] code;
      step_bytes.delete();
      case (mode)
        ced_pkg::MODE_ESC: begin
          if (is_oct(b)) begin
            mode       = ced_pkg::MODE_OCT;
            acc_value  = {1'b0, b - ced_pkg::CHAR_ZERO};
            oct_digits = 2'd1;
          end else if (b == ced_pkg::CHAR_X) begin
            mode      = ced_pkg::MODE_HEX0;
            acc_value = '0;
          end else begin
            code = b;
            case (b)
              ced_pkg::ESC_BELL_CH: code = ced_pkg::CODE_BELL;
              ced_pkg::ESC_BS_CH:   code = ced_pkg::CODE_BS;
              ced_pkg::ESC_TAB_CH:  code = ced_pkg::CODE_TAB;
              ced_pkg::ESC_LF_CH:   code = ced_pkg::CODE_LF;
              ced_pkg::ESC_VT_CH:   code = ced_pkg::CODE_VT;
              ced_pkg::ESC_FF_CH:   code = ced_pkg::CODE_FF;
              ced_pkg::ESC_CR_CH:   code = ced_pkg::CODE_CR;
              default:              code = b;
            endcase
            mode = ced_pkg::MODE_NORMAL;
            put(code, last);
          end
        end
        ced_pkg::MODE_OCT: begin
          if (is_oct(b)) begin
            acc_value  = {acc_value[5:0], 3'b000} + {1'b0, b - ced_pkg::CHAR_ZERO};
            oct_digits = oct_digits + 2'd1;
            // third digit closes the escape, value truncated to a byte
            if (oct_digits == 2'd3) begin
              mode = ced_pkg::MODE_NORMAL;
              put(acc_value[7:0], last);
            end
          end else begin
            put(acc_value[7:0], last);
            take_plain(b, last);
          end
        end
        ced_pkg::MODE_HEX0: begin
          if (is_hex(b)) begin
            mode      = ced_pkg::MODE_HEX1;
            acc_value = {5'b0, hex_digit(b)};
          end else begin
            put(ced_pkg::CHAR_X, last);
            take_plain(b, last);
          end
        end
        ced_pkg::MODE_HEX1: begin
          if (is_hex(b)) begin
            mode = ced_pkg::MODE_NORMAL;
            put({acc_value[3:0], hex_digit(b)}, last);
          end else begin
            put(acc_value[7:0], last);
            take_plain(b, last);
          end
        end
        default: take_plain(b, last);
      endcase

      // flush whatever is pending at the end of the string
      if (last) begin
        if (mode == ced_pkg::MODE_OCT || mode == ced_pkg::MODE_HEX1) begin
          put(acc_value[7:0], last);
        end else if (mode == ced_pkg::MODE_HEX0) begin
          put(ced_pkg::CHAR_X, last);
        end
        mode = ced_pkg::MODE_NORMAL;
      end
      if (mode == ced_pkg::MODE_NORMAL) begin
        acc_value  = '0;
        oct_digits = '0;
      end
      if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].run_last = 1'b1;
      foreach (step_bytes[k]) expected_bytes.push_back(step_bytes[k]);
    endfunction

    function void check_byte(ced_pkg::ced_result_t got);
      ced_pkg::ced_result_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: out_byte %02h run_last %0b string_end %0b",
               got.out_byte, got.run_last, got.string_end);
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %0b, actual %0b", want.run_last, got.run_last);
        mismatches++;
      end
      if (got.string_end !== want.string_end) begin
        $error("string_end: expected %0b, actual %0b", want.string_end, got.string_end);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   hold_off;
  bit   smooth;

  decoded_byte_tracker tracker = new();
  char_item_t          stim_q[$];

  ced_in_if  in_if ();
  ced_out_if out_if ();

  c_escape_sequence_decoder_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watch both channels; note inputs before checking outputs
  always @(posedge clk) begin : monitor
    ced_pkg::ced_result_t seen;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) tracker.note_char(in_if.in_byte, in_if.in_last);
      if (out_if.valid && out_if.ready) begin
        seen.out_byte   = out_if.out_byte;
        seen.run_last   = out_if.run_last;
        seen.string_end = out_if.string_end;
        tracker.check_byte(seen);
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void add_char(logic [7:0] ch, logic last);
    char_item_t it;
    it.ch   = ch;
    it.last = last;
    stim_q.push_back(it);
  endfunction

  function automatic void add_text(string s);
    for (int k = 0; k < s.len(); k++) add_char(s[k], k == s.len() - 1);
  endfunction

  // One string built from escape tokens, or now and then plain noise
  function automatic void add_random_string();
    logic [7:0] seq[$];
    string      letters = "abtnvfr";
    string      hexd = "0123456789abcdefABCDEF";
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 8)) seq.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 9))
          0, 1: seq.push_back(8'($urandom_range(0, 255)));
          2: begin
            seq.push_back(ced_pkg::CHAR_BSLASH);
            seq.push_back(letters[$urandom_range(0, 6)]);
          end
          3: begin
            seq.push_back(ced_pkg::CHAR_BSLASH);
            seq.push_back(8'($urandom_range(0, 255)));
          end
          4, 5: begin
            seq.push_back(ced_pkg::CHAR_BSLASH);
            repeat ($urandom_range(1, 3)) begin
              seq.push_back(8'(ced_pkg::CHAR_ZERO + $urandom_range(0, 7)));
            end
          end
          6, 7: begin
            seq.push_back(ced_pkg::CHAR_BSLASH);
            seq.push_back(ced_pkg::CHAR_X);
            repeat ($urandom_range(1, 2)) seq.push_back(hexd[$urandom_range(0, 21)]);
          end
          8: begin
            seq.push_back(ced_pkg::CHAR_BSLASH);
            seq.push_back(ced_pkg::CHAR_X);
          end
          default: begin
            seq.push_back(ced_pkg::CHAR_BSLASH);
            seq.push_back(ced_pkg::CHAR_BSLASH);
          end
        endcase
      end
      // trailing lone backslash
      if ($urandom_range(0, 9) == 0) seq.push_back(ced_pkg::CHAR_BSLASH);
    end
    foreach (seq[k]) add_char(seq[k], k == seq.size() - 1);
  endfunction

  task automatic send_char(char_item_t it);
    in_if.valid   <= 1'b1;
    in_if.in_byte <= it.ch;
    in_if.in_last <= it.last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic idle_in(int n);
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, one long hold-off, one stretch always ready
  initial begin : receiver
    int n;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else if (smooth) begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        n = gap_len();
        if (n == 0) n = 1;
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int directed;
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.in_byte <= 8'h00;
    in_if.in_last <= 1'b0;

    // extremes, control escapes, digit runs cut short, end-of-string flushes
    add_char(8'h00, 1'b0);
    add_char(8'hFF, 1'b1);
    add_text("\\a\\r");
    add_text("\\777\\7\\xAz");
    add_text("\\xg\\");
    add_text("\\x");
    add_text("\\xfF\\12");
    directed = stim_q.size();
    while (stim_q.size() < directed + RANDOM_ITEMS) add_random_string();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < stim_q.size(); i++) begin
      if (i == HOLD_AT) hold_off = 1'b1;
      if (i == SMOOTH_FROM) smooth = 1'b1;
      if (i == SMOOTH_TO) smooth = 1'b0;
      if (i == PAUSE_AT) begin
        in_if.valid <= 1'b0;
        wait_drained();
      end
      send_char(stim_q[i]);
      // keep offering while the output is held off so the queue fills
      if (!hold_off && !smooth) idle_in(gap_len());
    end
    in_if.valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);

    if (tracker.mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
